>>> src/dcrt_pkg.sv
// ----------------------------------------------------------------------------
// dcrt_pkg
// Shared types and constants of the duty-cycle relay timer.
// ----------------------------------------------------------------------------
package dcrt_pkg;

  localparam int unsigned CNT_W      = 26;
  localparam int unsigned LIM_W      = CNT_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Largest wrap limit and pulse length, one past the top count value.
  localparam logic [LIM_W-1:0] CNT_SPAN = LIM_W'(1) << CNT_W;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_SET_MODE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PAUSED  = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OVR_NONE         = 2'd0,
    OVR_FORCE_OFF    = 2'd1,
    OVR_FORCE_ON     = 2'd2,
    OVR_FORCE_ON_ALT = 2'd3
  } override_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_SECONDS        = 3'd0,
    CFG_PULSE_SECONDS         = 3'd1,
    CFG_TEMP_CONTROL_ENABLE   = 3'd2,
    CFG_TEMP_CONTROL_BLOCKING = 3'd3,
    CFG_RELAY_OVERRIDE        = 3'd4
  } cfg_idx_e;

  // Configuration as seen by the datapath, with the limits already in ticks.
  typedef struct packed {
    logic [LIM_W-1:0] wrap_limit;
    logic [LIM_W-1:0] pulse_limit;
    logic             temp_enable;
    logic             temp_blocking;
    logic [1:0]       relay_override;
  } dcrt_cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [1:0] mode_req;
    logic       temp_demand;
    logic       sensor_ready;
  } in_item_t;

  typedef struct packed {
    logic             relay_on;
    logic [1:0]       mode_now;
    logic [CNT_W-1:0] elapsed_ms;
  } out_item_t;

endpackage

>>> src/dcrt_if.sv
// ----------------------------------------------------------------------------
// dcrt_if
// Valid/ready channels of the duty-cycle relay timer: command words in,
// status words out.
// ----------------------------------------------------------------------------
interface dcrt_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] mode_req;
  logic       temp_demand;
  logic       sensor_ready;

  modport source (output valid, opcode, mode_req, temp_demand, sensor_ready,
                  input ready);
  modport sink (input valid, opcode, mode_req, temp_demand, sensor_ready,
                output ready);
endinterface

interface dcrt_out_if;
  logic        valid;
  logic        ready;
  logic        relay_on;
  logic [1:0]  mode_now;
  logic [25:0] elapsed_ms;

  modport source (output valid, relay_on, mode_now, elapsed_ms, input ready);
  modport sink (input valid, relay_on, mode_now, elapsed_ms, output ready);
endinterface

>>> src/dcrt_cfg.sv
// ----------------------------------------------------------------------------
// dcrt_cfg
// Configuration registers. Period and pulse are scaled to ticks and clamped
// to the counter span as they are written.
// ----------------------------------------------------------------------------
module dcrt_cfg #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dcrt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dcrt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output dcrt_pkg::dcrt_cfg_t              cfg_o
);
  import dcrt_pkg::*;

  localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned RAW_W  = CFG_DATA_W + TPS_W;
  localparam int unsigned PROD_W = (RAW_W > LIM_W) ? RAW_W : LIM_W;

  localparam longint unsigned SPAN_L     = longint'(1) << CNT_W;
  localparam longint unsigned WRAP_RAW   = 64'(60) * 64'(TICKS_PER_SECOND);
  localparam longint unsigned PULSE_RAW  = 64'(30) * 64'(TICKS_PER_SECOND);
  localparam logic [LIM_W-1:0] WRAP_RST  =
    LIM_W'((WRAP_RAW > SPAN_L) ? SPAN_L : WRAP_RAW);
  localparam logic [LIM_W-1:0] PULSE_RST =
    LIM_W'((PULSE_RAW > SPAN_L) ? SPAN_L : PULSE_RAW);

  logic [PROD_W-1:0] ticks_prod;
  logic [LIM_W-1:0]  ticks_lim;
  dcrt_cfg_t         cfg_q, cfg_d;

  // One multiplier serves both period and pulse writes.
  assign ticks_prod = PROD_W'(cfg_wdata_i) * PROD_W'(TICKS_PER_SECOND);
  assign ticks_lim  = (ticks_prod > PROD_W'(CNT_SPAN)) ? CNT_SPAN
                                                         : ticks_prod[LIM_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD_SECONDS:        cfg_d.wrap_limit     = ticks_lim;
        CFG_PULSE_SECONDS:         cfg_d.pulse_limit    = ticks_lim;
        CFG_TEMP_CONTROL_ENABLE:   cfg_d.temp_enable    = cfg_wdata_i[0];
        CFG_TEMP_CONTROL_BLOCKING: cfg_d.temp_blocking  = cfg_wdata_i[0];
        CFG_RELAY_OVERRIDE:        cfg_d.relay_override = cfg_wdata_i[1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_limit     <= WRAP_RST;
      cfg_q.pulse_limit    <= PULSE_RST;
      cfg_q.temp_enable    <= 1'b0;
      cfg_q.temp_blocking  <= 1'b0;
      cfg_q.relay_override <= OVR_NONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/duty_cycle_relay_timer_unit.sv
// ----------------------------------------------------------------------------
// duty_cycle_relay_timer_unit
// Duty-cycle relay timer: millisecond ticks and run-mode commands drive a
// cycle counter and a relay output, one status word per command word.
//
//   channel  dir  handshake     word
//   in_i     in   valid/ready   opcode, mode_req, temp_demand, sensor_ready
//   res_o    out  valid/ready   relay_on, mode_now, elapsed_ms
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
// A word is registered on acceptance and its status word is registered when
// it moves on; one word is taken every cycle while the output is not stalled.
// The counter, mode and relay state update in the cycle a word leaves the
// input register, so each word sees the state left by the one before it.
// A stalled output holds its word and the input register fills behind it.
// Reset leaves the timer stopped with the counter at zero and the relay off.
// ----------------------------------------------------------------------------
module duty_cycle_relay_timer_unit #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dcrt_in_if.sink                          in_i,
  dcrt_out_if.source                       res_o,
  input  logic                             cfg_we_i,
  input  logic [dcrt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dcrt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import dcrt_pkg::*;

  dcrt_cfg_t        cfg;
  logic             in_vld_q, in_vld_d;
  in_item_t         in_item_q, in_item_d;
  logic             out_vld_q, out_vld_d;
  out_item_t        out_item_q, out_item_d;
  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             relay_q, relay_d;
  logic             advance, process;
  logic [CNT_W-1:0] cnt_inc, cnt_tick;
  logic             cmd_valid;

  dcrt_cfg #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign advance    = !out_vld_q || res_o.ready;
  assign process    = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  always_comb begin
    in_item_d.opcode       = in_i.opcode;
    in_item_d.mode_req     = in_i.mode_req;
    in_item_d.temp_demand  = in_i.temp_demand;
    in_item_d.sensor_ready = in_i.sensor_ready;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (process) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  // Counter step for a running tick; it wraps to zero at the period limit.
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign cnt_tick = ({1'b0, cnt_inc} >= cfg.wrap_limit) ? '0 : cnt_inc;

  // Mode code three and a command to the current mode change nothing.
  assign cmd_valid = (in_item_q.mode_req == MODE_STOPPED ||
                      in_item_q.mode_req == MODE_PAUSED  ||
                      in_item_q.mode_req == MODE_RUNNING) &&
                     (in_item_q.mode_req != mode_q);

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    relay_d = relay_q;
    if (process) begin
      case (opcode_e'(in_item_q.opcode))
        OP_SET_MODE: begin
          if (cmd_valid) begin
            if (in_item_q.mode_req == MODE_STOPPED || mode_q == MODE_STOPPED) begin
              cnt_d = '0;
            end
            mode_d = mode_e'(in_item_q.mode_req);
          end
        end
        OP_TICK: begin
          case (mode_q)
            MODE_RUNNING: begin
              cnt_d = cnt_tick;
              if (cfg.relay_override != OVR_NONE) begin
                relay_d = cfg.relay_override[1];
              end else if (cfg.temp_enable && cfg.temp_blocking &&
                           in_item_q.sensor_ready) begin
                relay_d = in_item_q.temp_demand;
              end else begin
                relay_d = ({1'b0, cnt_tick} < cfg.pulse_limit) ||
                          in_item_q.temp_demand;
              end
            end
            MODE_STOPPED: relay_d = 1'b0;
            default:      relay_d = relay_q;
          endcase
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  always_comb begin
    out_item_d.relay_on   = relay_d;
    out_item_d.mode_now   = mode_d;
    out_item_d.elapsed_ms = cnt_d;
    if (process) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_STOPPED;
      cnt_q     <= '0;
      relay_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      relay_q   <= relay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_item_d;
    end
    if (process) begin
      out_item_q <= out_item_d;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.relay_on   = out_item_q.relay_on;
  assign res_o.mode_now   = out_item_q.mode_now;
  assign res_o.elapsed_ms = out_item_q.elapsed_ms;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the duty-cycle relay timer. A short directed run
// walks all mode changes but paused to stopped, and stopped and paused ticks.
// Random runs follow under several register settings, extremes included. A
// closing run of mostly running ticks, paused now and then, ends the test.
// Every status word is checked against a model of the timer kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcrt_pkg::*;

  localparam int unsigned TICKS_PER_S     = 1000;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [1:0]  MODE_CODE_SPARE = 2'd3;

  typedef struct {
    logic [15:0] period;
    logic [15:0] pulse;
    logic        temp_en;
    logic        temp_blk;
    logic [1:0]  override;
  } timer_settings_t;

  // Timer model and the queue of status words it has predicted.
  class relay_timer_checker;
    logic [15:0]      period;
    logic [15:0]      pulse;
    logic             temp_en;
    logic             temp_blk;
    logic [1:0]       override;
    mode_e            mode;
    logic [CNT_W-1:0] count;
    logic             relay;
    out_item_t        expected_status[$];
    int               errors;
    int               checked;
    int               wraps;
    int               relay_on_seen;

    function new();
      period   = 16'd60;
      pulse    = 16'd30;
      temp_en  = 1'b0;
      temp_blk = 1'b0;
      override = OVR_NONE;
      mode     = MODE_STOPPED;
      count    = '0;
      relay    = 1'b0;
    endfunction

    function void apply_settings(timer_settings_t s);
      period   = s.period;
      pulse    = s.pulse;
      temp_en  = s.temp_en;
      temp_blk = s.temp_blk;
      override = s.override;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void note_word(in_item_t w);
      out_item_t        s;
      longint unsigned  wrap_at;
      longint unsigned  on_ticks;
      logic [CNT_W-1:0] prev;
      if (w.opcode == OP_SET_MODE) begin
        if (w.mode_req <= MODE_RUNNING && w.mode_req != mode) begin
          // Leaving or entering the stopped mode always restarts the cycle.
          if (w.mode_req == MODE_STOPPED || mode == MODE_STOPPED) count = '0;
          mode = mode_e'(w.mode_req);
        end
      end else if (mode == MODE_RUNNING) begin
        prev    = count;
        count   = count + 1'b1;
        wrap_at = 64'(period) * TICKS_PER_S;
        if (wrap_at > 64'(CNT_SPAN)) wrap_at = 64'(CNT_SPAN);
        if (64'(count) >= wrap_at) count = '0;
        if (count == '0 && prev != '0) wraps++;
        on_ticks = 64'(pulse) * TICKS_PER_S;
        if (override != OVR_NONE) begin
          relay = override[1];
        end else if (temp_en && temp_blk && w.sensor_ready) begin
          relay = w.temp_demand;
        end else begin
          relay = (64'(count) < on_ticks) || w.temp_demand;
        end
      end else if (mode == MODE_STOPPED) begin
        relay = 1'b0;
      end
      s.relay_on   = relay;
      s.mode_now   = mode;
      s.elapsed_ms = count;
      expected_status.push_back(s);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected status word: relay %0b mode %0d elapsed %0d",
                   $realtime, got.relay_on, got.mode_now, got.elapsed_ms);
        return;
      end
      want = expected_status.pop_front();
      checked++;
      if (want.relay_on) relay_on_seen++;
      if (got.relay_on !== want.relay_on || got.mode_now !== want.mode_now ||
          got.elapsed_ms !== want.elapsed_ms) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: word %0d: expected relay %0b mode %0d elapsed %0d, got %0b %0d %0d",
                   $realtime, checked, want.relay_on, want.mode_now, want.elapsed_ms,
                   got.relay_on, got.mode_now, got.elapsed_ms);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  calm;
  int                    n_words;
  int                    n_settings;

  relay_timer_checker scb = new();

  dcrt_in_if  in_bus ();
  dcrt_out_if res_bus ();

  duty_cycle_relay_timer_unit #(
    .TICKS_PER_SECOND (TICKS_PER_S)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .res_o       (res_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short pauses, now and then a long one, none in a calm stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic in_item_t make_word(logic op, logic [1:0] m, logic d, logic rdy);
    in_item_t w;
    w.opcode       = op;
    w.mode_req     = m;
    w.temp_demand  = d;
    w.sensor_ready = rdy;
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t w;
    int       r;
    w.opcode       = ($urandom_range(99) < 70) ? OP_TICK : OP_SET_MODE;
    w.temp_demand  = 1'($urandom_range(1));
    w.sensor_ready = 1'($urandom_range(1));
    r = $urandom_range(9);
    if (w.opcode == OP_TICK) w.mode_req = 2'($urandom_range(3));
    else if (r < 5) w.mode_req = MODE_RUNNING;
    else if (r < 7) w.mode_req = MODE_PAUSED;
    else if (r < 9) w.mode_req = MODE_STOPPED;
    else w.mode_req = MODE_CODE_SPARE;
    return w;
  endfunction

  function automatic logic [15:0] random_seconds();
    if ($urandom_range(2) != 0) return 16'($urandom_range(0, 4));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic timer_settings_t settings(logic [15:0] p, logic [15:0] q, logic e,
                                               logic b, logic [1:0] o);
    timer_settings_t s;
    s.period   = p;
    s.pulse    = q;
    s.temp_en  = e;
    s.temp_blk = b;
    s.override = o;
    return s;
  endfunction

  // Valid stays high from one word to the next unless a pause comes between.
  task automatic send_word(in_item_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= w.opcode;
    in_bus.mode_req     <= w.mode_req;
    in_bus.temp_demand  <= w.temp_demand;
    in_bus.sensor_ready <= w.sensor_ready;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    scb.note_word(w);
    n_words++;
  endtask

  task automatic load_settings(timer_settings_t s);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PERIOD_SECONDS;
    cfg_wdata_i <= s.period;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PULSE_SECONDS;
    cfg_wdata_i <= s.pulse;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TEMP_CONTROL_ENABLE;
    cfg_wdata_i <= 16'(s.temp_en);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TEMP_CONTROL_BLOCKING;
    cfg_wdata_i <= 16'(s.temp_blk);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RELAY_OVERRIDE;
    cfg_wdata_i <= 16'(s.override);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scb.apply_settings(s);
    n_settings++;
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (scb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_word(make_word(OP_TICK, MODE_STOPPED, 1'b1, 1'b1));
    send_word(make_word(OP_SET_MODE, MODE_CODE_SPARE, 1'b0, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_STOPPED, 1'b0, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_PAUSED, 1'b1, 1'b0));
    send_word(make_word(OP_TICK, MODE_CODE_SPARE, 1'b0, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_RUNNING, 1'b0, 1'b1));
    send_word(make_word(OP_TICK, MODE_STOPPED, 1'b0, 1'b0));
    send_word(make_word(OP_TICK, MODE_RUNNING, 1'b1, 1'b1));
    send_word(make_word(OP_SET_MODE, MODE_PAUSED, 1'b0, 1'b0));
    send_word(make_word(OP_TICK, MODE_PAUSED, 1'b1, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_RUNNING, 1'b0, 1'b0));
    send_word(make_word(OP_TICK, MODE_PAUSED, 1'b0, 1'b1));
    send_word(make_word(OP_SET_MODE, MODE_CODE_SPARE, 1'b1, 1'b1));
    send_word(make_word(OP_SET_MODE, MODE_RUNNING, 1'b0, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_STOPPED, 1'b0, 1'b0));
    send_word(make_word(OP_TICK, MODE_RUNNING, 1'b1, 1'b1));
    send_word(make_word(OP_SET_MODE, MODE_RUNNING, 1'b0, 1'b0));
    send_word(make_word(OP_TICK, MODE_CODE_SPARE, 1'b0, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_STOPPED, 1'b1, 1'b0));
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_word(random_word());
  endtask

  // Mostly running ticks, with a pause now and then that is later resumed.
  task automatic run_long(int n);
    logic held;
    held = 1'b0;
    send_word(make_word(OP_SET_MODE, MODE_STOPPED, 1'b0, 1'b0));
    send_word(make_word(OP_SET_MODE, MODE_RUNNING, 1'b0, 1'b0));
    for (int i = 0; i < n; i++) begin
      if (held ? ($urandom_range(9) == 0) : ($urandom_range(19) == 0)) begin
        held = !held;
        send_word(make_word(OP_SET_MODE, held ? MODE_PAUSED : MODE_RUNNING,
                            1'($urandom_range(1)), 1'($urandom_range(1))));
      end else begin
        send_word(make_word(OP_TICK, 2'($urandom_range(3)), $urandom_range(9) == 0,
                            1'($urandom_range(1))));
      end
    end
  endtask

  initial begin : status_sink
    int stall;
    stall = 0;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
        if ($urandom_range(99) < 20) stall = idle_len();
      end
    end
  end

  initial begin : status_monitor
    out_item_t got;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        got.relay_on   = res_bus.relay_on;
        got.mode_now   = res_bus.mode_now;
        got.elapsed_ms = res_bus.elapsed_ms;
        scb.check_status(got);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles, %0d status words outstanding",
             $realtime, QUIET_LIMIT, scb.pending());
    $display("[duty_cycle_relay_timer_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    timer_settings_t plan[$];
    calm       = 1'b0;
    n_words    = 0;
    n_settings = 0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_PERIOD_SECONDS;
    cfg_wdata_i         <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.opcode       <= OP_TICK;
    in_bus.mode_req     <= MODE_STOPPED;
    in_bus.temp_demand  <= 1'b0;
    in_bus.sensor_ready <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values stay in force for the directed words.
    run_directed();
    settle();

    plan.push_back(settings(16'd0, 16'd0, 1'b0, 1'b0, OVR_NONE));
    plan.push_back(settings(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, OVR_NONE));
    plan.push_back(settings(16'd1, 16'd0, 1'b1, 1'b0, OVR_FORCE_OFF));
    plan.push_back(settings(16'd3, 16'hFFFF, 1'b0, 1'b1, OVR_FORCE_ON));
    plan.push_back(settings(16'd0, 16'd1, 1'b1, 1'b1, OVR_FORCE_ON_ALT));
    plan.push_back(settings(16'd2, 16'd0, 1'b1, 1'b1, OVR_NONE));
    for (int i = 0; i < 4; i++)
      plan.push_back(settings(random_seconds(), random_seconds(), 1'($urandom_range(1)),
                              1'($urandom_range(1)),
                              ($urandom_range(1) != 0) ? 2'($urandom_range(3)) : OVR_NONE));
    foreach (plan[i]) begin
      calm = (i % 3 == 2);
      load_settings(plan[i]);
      run_random(60);
      settle();
    end

    calm = 1'b0;
    load_settings(settings(16'd2, 16'd1, 1'b0, 1'b0, OVR_NONE));
    run_long(80);
    settle();

    $display("Ran %0d command words under %0d register settings; %0d status words checked.",
             n_words, n_settings, scb.checked);
    $display("The cycle counter wrapped %0d times and the relay was on in %0d status words.",
             scb.wraps, scb.relay_on_seen);
    if (scb.errors == 0 && scb.pending() == 0) begin
      $display("[duty_cycle_relay_timer_unit] OK");
    end else begin
      $display("%0d mismatches, %0d status words never arrived", scb.errors, scb.pending());
      $display("[duty_cycle_relay_timer_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> duty_cycle_relay_timer_unit.f
src/dcrt_pkg.sv
src/dcrt_if.sv
src/dcrt_cfg.sv
src/duty_cycle_relay_timer_unit.sv
sim/testbench.sv
